### rtl/gla_pkg.sv
// Shared types, constants and codes for the gate layer assigner.
package gla_pkg;

	localparam int QUBITS     = 128;
	localparam int QUBIT_W    = 7;
	localparam int LAYER_W    = 16;
	localparam int MODE_W     = 3;
	localparam int NQ_W       = 8;
	localparam int CFG_DW     = 8;
	localparam int STATUS_W   = 2;
	localparam int FIFO_DEPTH = 2;
	localparam int TRI_N      = 3;

	localparam logic [LAYER_W-1:0] LAYER_MAX = {LAYER_W{1'b1}};

	localparam logic [MODE_W-1:0] MODE_INDIV = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DISJ  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ODD   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TRI   = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BADQ = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_OVF  = 2'd2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_NQ   = 1'b1;

	// one queued gate, already range-checked
	typedef struct packed {
		logic               first;
		logic               two;
		logic               same;
		logic               bad;
		logic [QUBIT_W-1:0] c;
		logic [QUBIT_W-1:0] t;
	} gate_t;

	// per-qubit table entry
	typedef struct packed {
		logic [LAYER_W-1:0] layer;
		logic [QUBIT_W-1:0] partner;
	} tbl_entry_t;

	localparam int GATE_W = $bits(gate_t);
	localparam int TBL_W  = $bits(tbl_entry_t);

endpackage

### rtl/gla_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module gla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### rtl/gla_front.sv
// Front end: accepts gates, range-checks qubit indices and queues them.
module gla_front (
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           first_of_circuit,
	input  logic                           is_two_qubit,
	input  logic [gla_pkg::QUBIT_W-1:0]    control_qubit,
	input  logic [gla_pkg::QUBIT_W-1:0]    target_qubit,
	input  logic [gla_pkg::NQ_W-1:0]       num_qubits,
	input  logic                           full,
	output logic                           push,
	output gla_pkg::gate_t                 push_data
);

	logic t_bad;
	logic c_bad;

	// limit is min(num_qubits, QUBITS)
	assign t_bad = (32'(target_qubit) >= 32'(num_qubits)) ||
		(32'(target_qubit) >= gla_pkg::QUBITS);
	assign c_bad = (32'(control_qubit) >= 32'(num_qubits)) ||
		(32'(control_qubit) >= gla_pkg::QUBITS);

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		push_data       = '0;
		push_data.first = first_of_circuit;
		push_data.two   = is_two_qubit;
		push_data.same  = !is_two_qubit || (control_qubit == target_qubit);
		push_data.bad   = t_bad || (is_two_qubit && c_bad);
		// single-qubit gates look up the target on both ports
		push_data.c     = is_two_qubit ? control_qubit : target_qubit;
		push_data.t     = target_qubit;
	end

endmodule

### rtl/gla_fifo.sv
// Short queue of classified gates between front and back end.
module gla_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gla_pkg::gate_t wdata,
	output logic           full,
	input  logic           pop,
	output gla_pkg::gate_t rdata,
	output logic           empty
);

	localparam int AW = $clog2(gla_pkg::FIFO_DEPTH);

	gla_pkg::gate_t slot_q [gla_pkg::FIFO_DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [AW:0]    cnt_q;

	assign full  = (cnt_q == (AW+1)'(gla_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(gla_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(gla_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/gla_back.sv
// Back end: per-qubit table, layer bookkeeping and result register.
module gla_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gla_pkg::MODE_W-1:0]    layering_mode,
	input  logic                          empty,
	input  gla_pkg::gate_t                head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gla_pkg::LAYER_W-1:0]   layer_index,
	output logic [gla_pkg::LAYER_W-1:0]   layer_count,
	output logic [gla_pkg::STATUS_W-1:0]  status
);

	localparam int LW = gla_pkg::LAYER_W;
	localparam int QW = gla_pkg::QUBIT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WR2  = 2'd2;

	logic [1:0]            st_q;
	gla_pkg::gate_t        item_q;
	logic [gla_pkg::QUBITS-1:0] valid_q;
	logic [LW-1:0]         total_q;
	logic                  toggle_q;
	logic [QW-1:0]         tri_q [gla_pkg::TRI_N];
	logic [1:0]            fill_q;
	logic                  out_valid_q;
	logic [LW-1:0]         layer_index_q;
	logic [LW-1:0]         layer_count_q;
	logic [gla_pkg::STATUS_W-1:0] status_q;
	logic [QW-1:0]         wr2_addr_q;
	gla_pkg::tbl_entry_t   wr2_data_q;

	logic [QW-1:0]         raddr_c;
	logic [QW-1:0]         raddr_t;
	gla_pkg::tbl_entry_t   rd_c;
	gla_pkg::tbl_entry_t   rd_t;
	logic                  ram_we;
	logic [QW-1:0]         ram_waddr;
	gla_pkg::tbl_entry_t   ram_wdata;

	logic                  fire;
	logic                  clr;
	logic [LW-1:0]         tot_e;
	logic                  tog_e;
	logic [1:0]            fill_e;
	logic                  vc;
	logic                  vt;
	logic [LW-1:0]         lmax;
	logic [LW:0]           lay;
	logic [LW-1:0]         tri_tot;
	logic                  ovf;
	logic                  err;
	logic [LW-1:0]         tot_n;
	logic                  tog_n;
	logic [QW-1:0]         tri_n [gla_pkg::TRI_N];
	logic [1:0]            fill_n;
	logic [1:0]            fill_mid;
	logic                  in_c;
	logic                  in_t;
	logic [2:0]            add;
	logic                  tbl_wr;
	logic                  tbl_wr2;
	logic [QW-1:0]         wa1;
	gla_pkg::tbl_entry_t   wd1;
	logic [gla_pkg::QUBITS-1:0] valid_n;

	gla_ram #(
		.WIDTH (gla_pkg::TBL_W),
		.DEPTH (gla_pkg::QUBITS)
	) u_tbl (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_c),
		.raddr_b (raddr_t),
		.rdata_a (rd_c),
		.rdata_b (rd_t)
	);

	assign pop     = (st_q == S_IDLE) && !empty;
	// hold read addresses while the entry waits in EXEC
	assign raddr_c = (st_q == S_IDLE) ? head.c : item_q.c;
	assign raddr_t = (st_q == S_IDLE) ? head.t : item_q.t;
	assign fire    = (st_q == S_EXEC) && (!out_valid_q || out_ready);

	always_comb begin
		clr    = item_q.first;
		tot_e  = clr ? '0 : total_q;
		tog_e  = clr || toggle_q;
		fill_e = clr ? 2'd0 : fill_q;
		vc     = !clr && valid_q[item_q.c];
		vt     = !clr && valid_q[item_q.t];
		lmax   = (rd_c.layer > rd_t.layer) ? rd_c.layer : rd_t.layer;
		tri_tot = (tot_e == '0) ? LW'(1) : tot_e;

		in_c = 1'b0;
		in_t = 1'b0;
		for (int i = 0; i < gla_pkg::TRI_N; i++) begin
			if (2'(i) < fill_e && tri_q[i] == item_q.c) in_c = 1'b1;
			if (2'(i) < fill_e && tri_q[i] == item_q.t) in_t = 1'b1;
		end
		add = 3'(!in_c) + 3'(!item_q.same && !in_t);

		lay     = '0;
		ovf     = 1'b0;
		tot_n   = tot_e;
		tog_n   = tog_e;
		fill_n  = fill_e;
		fill_mid = fill_e;
		tbl_wr  = 1'b0;
		tbl_wr2 = 1'b0;
		wa1     = item_q.t;
		wd1     = rd_t;
		for (int i = 0; i < gla_pkg::TRI_N; i++) begin
			tri_n[i] = tri_q[i];
		end

		unique case (layering_mode) inside
			gla_pkg::MODE_INDIV: begin
				if (tot_e == gla_pkg::LAYER_MAX) begin
					ovf = 1'b1;
				end else begin
					lay   = {1'b0, tot_e};
					tot_n = tot_e + 1'b1;
				end
			end
			gla_pkg::MODE_DISJ, gla_pkg::MODE_BLOCK: begin
				if (!item_q.two) begin
					if (vt) begin
						lay = {1'b0, rd_t.layer} +
							(LW+1)'(layering_mode == gla_pkg::MODE_DISJ);
					end
				end else if (!vc && !vt) begin
					lay = '0;
				end else if (!vc) begin
					lay = {1'b0, rd_t.layer} + 1'b1;
				end else if (!vt) begin
					lay = {1'b0, rd_c.layer} + 1'b1;
				end else begin
					lay = {1'b0, lmax} + 1'b1;
					// same pair met last in the same layer: reuse it
					if (layering_mode == gla_pkg::MODE_BLOCK &&
						rd_c.layer == rd_t.layer &&
						rd_c.partner == item_q.t && rd_t.partner == item_q.c) begin
						lay = {1'b0, lmax};
					end
				end
				if (lay >= {1'b0, tot_e} && tot_e == gla_pkg::LAYER_MAX) begin
					ovf = 1'b1;
				end else if (lay >= {1'b0, tot_e}) begin
					tot_n = LW'(lay + 1'b1);
				end
				if (item_q.two) begin
					tbl_wr  = 1'b1;
					tbl_wr2 = !item_q.same;
					wa1     = item_q.c;
					wd1     = {lay[LW-1:0], item_q.t};
				end else if (layering_mode == gla_pkg::MODE_DISJ) begin
					tbl_wr = 1'b1;
					wa1    = item_q.t;
					wd1    = {lay[LW-1:0], rd_t.partner};
				end
			end
			gla_pkg::MODE_ODD: begin
				if (tog_e || tot_e == '0) begin
					if (tot_e == gla_pkg::LAYER_MAX) begin
						ovf = 1'b1;
					end else begin
						tot_n = tot_e + 1'b1;
					end
				end
				lay   = {1'b0, tot_n - 1'b1};
				tog_n = !tog_e;
			end
			gla_pkg::MODE_TRI: begin
				tot_n = tri_tot;
				if (item_q.two) begin
					if (3'(fill_e) + add <= 3'd3) begin
						if (!in_c) begin
							tri_n[fill_e] = item_q.c;
							fill_mid = fill_e + 1'b1;
						end
						fill_n = fill_mid;
						if (!item_q.same && !in_t) begin
							tri_n[fill_mid] = item_q.t;
							fill_n = fill_mid + 1'b1;
						end
					end else if (tri_tot == gla_pkg::LAYER_MAX) begin
						ovf = 1'b1;
					end else begin
						// open a new layer seeded with this pair
						tot_n    = tri_tot + 1'b1;
						tri_n[0] = item_q.c;
						tri_n[1] = item_q.t;
						fill_n   = item_q.same ? 2'd1 : 2'd2;
					end
				end
				lay = {1'b0, tot_n - 1'b1};
			end
			default: begin
				lay = '0;
			end
		endcase

		err = item_q.bad || ovf;
		valid_n = clr ? '0 : valid_q;
		if (!err && tbl_wr) begin
			valid_n[wa1] = 1'b1;
			if (tbl_wr2) valid_n[item_q.t] = 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa1;
		ram_wdata = wd1;
		if (fire && !err && tbl_wr) begin
			ram_we = 1'b1;
		end else if (st_q == S_WR2) begin
			ram_we    = 1'b1;
			ram_waddr = wr2_addr_q;
			ram_wdata = wr2_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (fire) begin
			wr2_addr_q    <= item_q.t;
			wr2_data_q    <= {lay[LW-1:0], item_q.c};
			layer_index_q <= err ? '0 : lay[LW-1:0];
			layer_count_q <= err ? tot_e : tot_n;
			status_q      <= item_q.bad ? gla_pkg::STAT_BADQ :
				(ovf ? gla_pkg::STAT_OVF : gla_pkg::STAT_OK);
			for (int i = 0; i < gla_pkg::TRI_N; i++) begin
				tri_q[i] <= err ? tri_q[i] : tri_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			valid_q     <= '0;
			total_q     <= '0;
			toggle_q    <= 1'b1;
			fill_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (pop) st_q <= S_EXEC;
				end
				S_EXEC: begin
					if (fire) begin
						out_valid_q <= 1'b1;
						valid_q     <= valid_n;
						total_q     <= err ? tot_e : tot_n;
						toggle_q    <= err ? tog_e : tog_n;
						fill_q      <= err ? fill_e : fill_n;
						st_q        <= (!err && tbl_wr2) ? S_WR2 : S_IDLE;
					end
				end
				S_WR2: begin
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign layer_index = layer_index_q;
	assign layer_count = layer_count_q;
	assign status      = status_q;

endmodule

### rtl/gate_layer_assigner.sv
// Gate layer assigner top level: configuration registers, front end, queue, back end.
// Each item passes the queue, the item register (table read) and the result register.
// The back end takes one item at a time: IDLE, EXEC, and WR2 when a two-qubit item on
// distinct qubits is placed in mode 1 or 2 (second write through the single write port of
// the per-qubit table). Reset: asynchronous, clears queue, layer state and per-qubit valid
// bits at once; mode resets to 0 and num_qubits to 128.
module gate_layer_assigner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic                          cfg_addr,
	input  logic [gla_pkg::CFG_DW-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          first_of_circuit,
	input  logic                          is_two_qubit,
	input  logic [gla_pkg::QUBIT_W-1:0]   control_qubit,
	input  logic [gla_pkg::QUBIT_W-1:0]   target_qubit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gla_pkg::LAYER_W-1:0]   layer_index,
	output logic [gla_pkg::LAYER_W-1:0]   layer_count,
	output logic [gla_pkg::STATUS_W-1:0]  status
);

	logic [gla_pkg::MODE_W-1:0] layering_mode_q;
	logic [gla_pkg::NQ_W-1:0]   num_qubits_q;

	logic           full;
	logic           empty;
	logic           push;
	logic           pop;
	gla_pkg::gate_t push_data;
	gla_pkg::gate_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layering_mode_q <= gla_pkg::MODE_INDIV;
			num_qubits_q    <= gla_pkg::NQ_W'(gla_pkg::QUBITS);
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				gla_pkg::REG_MODE: layering_mode_q <= cfg_wdata[gla_pkg::MODE_W-1:0];
				gla_pkg::REG_NQ:   num_qubits_q    <= cfg_wdata[gla_pkg::NQ_W-1:0];
				default:           layering_mode_q <= layering_mode_q;
			endcase
		end
	end

	gla_front u_front (
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.first_of_circuit (first_of_circuit),
		.is_two_qubit     (is_two_qubit),
		.control_qubit    (control_qubit),
		.target_qubit     (target_qubit),
		.num_qubits       (num_qubits_q),
		.full             (full),
		.push             (push),
		.push_data        (push_data)
	);

	gla_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	gla_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.layering_mode (layering_mode_q),
		.empty         (empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.layer_index   (layer_index),
		.layer_count   (layer_count),
		.status        (status)
	);

endmodule

### rtl/gla_checker.sv
// Port-level checker for the gate layer assigner, bound to the top level.
module gla_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [gla_pkg::LAYER_W-1:0]   layer_index,
	input logic [gla_pkg::LAYER_W-1:0]   layer_count,
	input logic [gla_pkg::STATUS_W-1:0]  status
);

	// failed items carry layer zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != gla_pkg::STAT_OK |-> layer_index == '0)
		else $error("failed item with nonzero layer index");

	// assigned layer lies below the layer count
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gla_pkg::STAT_OK && layer_count != '0
		|-> layer_index < layer_count)
		else $error("layer index not below layer count");

	// overflow only when the count is saturated
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gla_pkg::STAT_OVF |-> layer_count == gla_pkg::LAYER_MAX)
		else $error("overflow reported below the layer limit");

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(layer_index) &&
		$stable(layer_count) && $stable(status))
		else $error("stalled result changed");

endmodule

bind gate_layer_assigner gla_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.layer_index (layer_index),
	.layer_count (layer_count),
	.status      (status)
);

### sim/gate_layer_assigner_tb.sv
// Self-checking testbench for gate_layer_assigner: directed table and random circuits.
module gate_layer_assigner_tb;
	import gla_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 80;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 120;
	localparam int LMAX        = int'(LAYER_MAX);
	localparam bit TYPED       = 1'b1;
	localparam bit PRED        = 1'b0;

	localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

	typedef struct packed {
		logic [LAYER_W-1:0]  idx;
		logic [LAYER_W-1:0]  cnt;
		logic [STATUS_W-1:0] st;
	} layer_result_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [NQ_W-1:0]    nq;
		logic               first;
		logic               two;
		logic [QUBIT_W-1:0] c;
		logic [QUBIT_W-1:0] t;
		logic               typed;
		layer_result_t      res;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic first_of_circuit;
	logic is_two_qubit;
	logic [QUBIT_W-1:0] control_qubit;
	logic [QUBIT_W-1:0] target_qubit;
	logic out_valid;
	logic out_ready;
	logic [LAYER_W-1:0] layer_index;
	logic [LAYER_W-1:0] layer_count;
	logic [STATUS_W-1:0] status;

	// scheduler state as the block should hold it
	logic [LAYER_W-1:0] lay_tbl [QUBITS];
	bit                 valid_tbl [QUBITS];
	logic [QUBIT_W-1:0] partner_tbl [QUBITS];
	int                 n_layers;
	bit                 toggle;
	logic [QUBIT_W-1:0] tri_q [TRI_N];
	int                 tri_n;
	logic [MODE_W-1:0]  cur_mode;
	logic [NQ_W-1:0]    cur_nq;

	layer_result_t expected_layers [$];
	layer_result_t want;
	int errors = 0;
	int cycle_cnt = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	logic [QUBIT_W-1:0] pair_a = '0;
	logic [QUBIT_W-1:0] pair_b = '0;

	plan_row_t plan [27] = '{
		'{MODE_INDIV, 8'd128, 1'b1, 1'b0, 7'd0,   7'd0,   TYPED, '{16'd0, 16'd1, STAT_OK}},
		'{MODE_INDIV, 8'd128, 1'b0, 1'b1, 7'd127, 7'd127, TYPED, '{16'd1, 16'd2, STAT_OK}},
		'{MODE_INDIV, 8'd128, 1'b0, 1'b1, 7'd0,   7'd127, PRED,  '0},
		'{MODE_INDIV, 8'd1,   1'b0, 1'b0, 7'd0,   7'd1,   TYPED, '{16'd0, 16'd3, STAT_BADQ}},
		'{MODE_INDIV, 8'd1,   1'b0, 1'b1, 7'd1,   7'd0,   TYPED, '{16'd0, 16'd3, STAT_BADQ}},
		'{MODE_INDIV, 8'd1,   1'b0, 1'b1, 7'd0,   7'd0,   PRED,  '0},
		'{MODE_INDIV, 8'd128, 1'b1, 1'b0, 7'd0,   7'd127, TYPED, '{16'd0, 16'd1, STAT_OK}},
		'{MODE_DISJ,  8'd128, 1'b1, 1'b0, 7'd0,   7'd5,   TYPED, '{16'd0, 16'd1, STAT_OK}},
		'{MODE_DISJ,  8'd128, 1'b0, 1'b0, 7'd0,   7'd5,   PRED,  '0},
		'{MODE_DISJ,  8'd128, 1'b0, 1'b1, 7'd5,   7'd9,   PRED,  '0},
		'{MODE_DISJ,  8'd128, 1'b0, 1'b1, 7'd9,   7'd9,   PRED,  '0},
		'{MODE_BLOCK, 8'd128, 1'b1, 1'b0, 7'd0,   7'd3,   PRED,  '0},
		'{MODE_BLOCK, 8'd128, 1'b0, 1'b1, 7'd3,   7'd4,   PRED,  '0},
		'{MODE_BLOCK, 8'd128, 1'b0, 1'b1, 7'd4,   7'd3,   PRED,  '0},
		'{MODE_BLOCK, 8'd128, 1'b0, 1'b0, 7'd0,   7'd4,   PRED,  '0},
		'{MODE_BLOCK, 8'd128, 1'b0, 1'b1, 7'd4,   7'd6,   PRED,  '0},
		'{MODE_BLOCK, 8'd128, 1'b0, 1'b1, 7'd3,   7'd4,   PRED,  '0},
		'{MODE_ODD,   8'd128, 1'b1, 1'b0, 7'd0,   7'd0,   TYPED, '{16'd0, 16'd1, STAT_OK}},
		'{MODE_ODD,   8'd128, 1'b0, 1'b0, 7'd0,   7'd1,   PRED,  '0},
		'{MODE_ODD,   8'd128, 1'b0, 1'b1, 7'd1,   7'd2,   PRED,  '0},
		'{MODE_TRI,   8'd128, 1'b1, 1'b0, 7'd0,   7'd0,   TYPED, '{16'd0, 16'd1, STAT_OK}},
		'{MODE_TRI,   8'd128, 1'b0, 1'b1, 7'd1,   7'd2,   PRED,  '0},
		'{MODE_TRI,   8'd128, 1'b0, 1'b1, 7'd2,   7'd3,   PRED,  '0},
		'{MODE_TRI,   8'd128, 1'b0, 1'b1, 7'd1,   7'd4,   PRED,  '0},
		'{MODE_TRI,   8'd128, 1'b0, 1'b1, 7'd7,   7'd7,   PRED,  '0},
		'{MODE_RSVD5, 8'd128, 1'b0, 1'b1, 7'd0,   7'd1,   TYPED, '{16'd0, 16'd2, STAT_OK}},
		'{MODE_RSVD7, 8'd1,   1'b0, 1'b0, 7'd0,   7'd127, TYPED, '{16'd0, 16'd2, STAT_BADQ}}
	};

	gate_layer_assigner u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.first_of_circuit (first_of_circuit),
		.is_two_qubit     (is_two_qubit),
		.control_qubit    (control_qubit),
		.target_qubit     (target_qubit),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.layer_index      (layer_index),
		.layer_count      (layer_count),
		.status           (status)
	);

	always #6 clk = ~clk;

	function automatic bit tri_has(logic [QUBIT_W-1:0] q);
		for (int i = 0; i < tri_n; i++)
			if (tri_q[i] == q)
				return 1'b1;
		return 1'b0;
	endfunction

	// Place one gate: update the layer state and return the result the block owes.
	function automatic layer_result_t place_gate(bit first, bit two, logic [QUBIT_W-1:0] c,
			logic [QUBIT_W-1:0] t);
		layer_result_t r;
		logic [STATUS_W-1:0] st;
		int lim;
		int lay;
		int tot;
		int add;
		bit c_in;
		if (first) begin
			valid_tbl = '{default: 1'b0};
			n_layers = 0;
			toggle = 1'b1;
			tri_n = 0;
		end
		st = STAT_OK;
		lay = 0;
		lim = (cur_nq < QUBITS) ? int'(cur_nq) : QUBITS;
		if (int'(t) >= lim || (two && int'(c) >= lim)) begin
			st = STAT_BADQ;
		end else begin
			case (cur_mode) inside
			MODE_INDIV: begin
				if (n_layers >= LMAX)
					st = STAT_OVF;
				else begin
					lay = n_layers;
					n_layers++;
				end
			end
			MODE_DISJ, MODE_BLOCK: begin
				if (!two) begin
					if (valid_tbl[t])
						lay = int'(lay_tbl[t]) + ((cur_mode == MODE_DISJ) ? 1 : 0);
				end else if (!valid_tbl[c] && !valid_tbl[t]) begin
					lay = 0;
				end else if (!valid_tbl[c]) begin
					lay = int'(lay_tbl[t]) + 1;
				end else if (!valid_tbl[t]) begin
					lay = int'(lay_tbl[c]) + 1;
				end else begin
					lay = ((lay_tbl[c] > lay_tbl[t]) ? int'(lay_tbl[c]) : int'(lay_tbl[t])) + 1;
					// reuse the layer where this exact pair last met
					if (cur_mode == MODE_BLOCK && lay_tbl[c] == lay_tbl[t] &&
							partner_tbl[c] == t && partner_tbl[t] == c)
						lay--;
				end
				if (lay >= n_layers && n_layers >= LMAX) begin
					st = STAT_OVF;
				end else begin
					if (lay >= n_layers)
						n_layers = lay + 1;
					if (two) begin
						lay_tbl[c] = lay[LAYER_W-1:0];
						valid_tbl[c] = 1'b1;
						lay_tbl[t] = lay[LAYER_W-1:0];
						valid_tbl[t] = 1'b1;
						partner_tbl[c] = t;
						partner_tbl[t] = c;
					end else if (cur_mode == MODE_DISJ) begin
						lay_tbl[t] = lay[LAYER_W-1:0];
						valid_tbl[t] = 1'b1;
					end
				end
			end
			MODE_ODD: begin
				if (toggle || n_layers == 0) begin
					if (n_layers >= LMAX)
						st = STAT_OVF;
					else
						n_layers++;
				end
				if (st == STAT_OK) begin
					lay = n_layers - 1;
					toggle = !toggle;
				end
			end
			MODE_TRI: begin
				tot = (n_layers == 0) ? 1 : n_layers;
				if (two) begin
					c_in = tri_has(c);
					add = 0;
					if (!c_in)
						add++;
					if (t != c && !tri_has(t))
						add++;
					if (tri_n + add <= TRI_N) begin
						if (!c_in) begin
							tri_q[tri_n] = c;
							tri_n++;
						end
						if (!tri_has(t) && tri_n < TRI_N) begin
							tri_q[tri_n] = t;
							tri_n++;
						end
					end else if (tot >= LMAX) begin
						st = STAT_OVF;
					end else begin
						tot++;
						tri_q[0] = c;
						tri_n = 1;
						if (t != c) begin
							tri_q[1] = t;
							tri_n = 2;
						end
					end
				end
				if (st == STAT_OK) begin
					n_layers = tot;
					lay = tot - 1;
				end
			end
			default: lay = 0;
			endcase
		end
		r.idx = (st == STAT_OK) ? lay[LAYER_W-1:0] : '0;
		r.cnt = n_layers[LAYER_W-1:0];
		r.st = st;
		return r;
	endfunction

	// Offer one item from a falling edge; return at a falling edge after it is taken.
	task automatic send_gate(bit first, bit two, logic [QUBIT_W-1:0] c, logic [QUBIT_W-1:0] t,
			bit typed, layer_result_t typed_res);
		layer_result_t pred;
		in_valid <= 1'b1;
		first_of_circuit <= first;
		is_two_qubit <= two;
		control_qubit <= c;
		target_qubit <= t;
		do
			@(posedge clk);
		while (!in_ready);
		pred = place_gate(first, two, c, t);
		expected_layers.push_back(typed ? typed_res : pred);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		while (expected_layers.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(logic [MODE_W-1:0] mode, logic [NQ_W-1:0] nq);
		cfg_wen <= 1'b1;
		cfg_addr <= REG_MODE;
		cfg_wdata <= CFG_DW'(mode);
		@(negedge clk);
		cfg_addr <= REG_NQ;
		cfg_wdata <= nq;
		@(negedge clk);
		cfg_wen <= 1'b0;
		cur_mode = mode;
		cur_nq = nq;
	endtask

	task automatic rand_gate(input int pool, output bit first, output bit two,
			output logic [QUBIT_W-1:0] c, output logic [QUBIT_W-1:0] t);
		first = ($urandom_range(0, 39) == 0);
		two = ($urandom_range(0, 3) != 0);
		c = QUBIT_W'($urandom_range(0, pool - 1));
		t = QUBIT_W'($urandom_range(0, pool - 1));
		// repeat the last pair often so block reuse and triangle joins happen
		if (two && $urandom_range(0, 2) == 0) begin
			if ($urandom_range(0, 1)) begin
				c = pair_a;
				t = pair_b;
			end else begin
				c = pair_b;
				t = pair_a;
			end
		end
		if ($urandom_range(0, 15) == 0)
			c = t;
		if ($urandom_range(0, 24) == 0)
			t = QUBIT_W'($urandom_range(0, QUBITS - 1));
		if ($urandom_range(0, 24) == 0)
			c = QUBIT_W'($urandom_range(0, QUBITS - 1));
		pair_a = c;
		pair_b = t;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_layers.size() == 0) begin
				errors++;
				$error("result with no item pending: layer_index %0d layer_count %0d status %0d",
					layer_index, layer_count, status);
			end else begin
				want = expected_layers.pop_front();
				if (layer_index !== want.idx) begin
					errors++;
					$error("layer_index: expected %0d, actual %0d", want.idx, layer_index);
				end
				if (layer_count !== want.cnt) begin
					errors++;
					$error("layer_count: expected %0d, actual %0d", want.cnt, layer_count);
				end
				if (status !== want.st) begin
					errors++;
					$error("status: expected %0d, actual %0d", want.st, status);
				end
			end
		end
	end

	// result side: random stalls plus one long hold so the input side backs up
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		bit first;
		bit two;
		logic [QUBIT_W-1:0] c;
		logic [QUBIT_W-1:0] t;
		logic [MODE_W-1:0] mode;
		logic [NQ_W-1:0] nq;
		int pool;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_addr = REG_MODE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		first_of_circuit = 1'b0;
		is_two_qubit = 1'b0;
		control_qubit = '0;
		target_qubit = '0;
		valid_tbl = '{default: 1'b0};
		n_layers = 0;
		toggle = 1'b1;
		tri_n = 0;
		cur_mode = MODE_INDIV;
		cur_nq = 8'd128;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].mode != cur_mode || plan[i].nq != cur_nq) begin
				in_valid <= 1'b0;
				drain_results();
				write_cfg(plan[i].mode, plan[i].nq);
			end
			send_gate(plan[i].first, plan[i].two, plan[i].c, plan[i].t, plan[i].typed,
				plan[i].res);
		end
		in_valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			mode = (ph < 10) ? MODE_W'(ph % 5) : MODE_W'($urandom_range(0, 4));
			case (ph)
			0: nq = 8'd128;
			1: nq = 8'd1;
			2: nq = 8'd2;
			default: nq = ($urandom_range(0, 2) == 0) ? 8'd128 : NQ_W'($urandom_range(1, 128));
			endcase
			pool = (ph == 0 || $urandom_range(0, 1)) ? int'(nq) :
				$urandom_range(1, (nq < 10) ? int'(nq) : 10);
			drain_results();
			write_cfg(mode, nq);
			// the last phases run with no idling on either side
			if (ph >= PHASES - 2)
				idle_on = 1'b0;
			else
				idle_on = (ph == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
			if (ph == 3)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				rand_gate(pool, first, two, c, t);
				// open each phase with a fresh circuit so no stale pair data is read
				if (k == 0)
					first = 1'b1;
				send_gate(first, two, c, t, PRED, '0);
			end
			in_valid <= 1'b0;
		end

		while (expected_layers.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
